// ===== sv/sector_remap_allocator_macros.svh =====
// Assertion helpers for the sector remap allocator checker.
`ifndef SECTOR_REMAP_ALLOCATOR_MACROS_SVH
`define SECTOR_REMAP_ALLOCATOR_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the local clk and rst_n names.
`define SRA_ASSERT_CLK(lbl, prop, msg) `SRA_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

// ===== sv/srmap_pkg.sv =====
`timescale 1ns / 1ps
package srmap_pkg;

  localparam int ACTION_W   = 2;
  localparam int SECTOR_W   = 10;
  localparam int OFFSET_W   = 9;
  localparam int ADDR_W     = 17;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 8;
  localparam int PHYS_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_LOGICAL_SECTORS = 1024;

  localparam logic [PHYS_W-1:0] MAX_PHYS_SLOTS = 9'd256;
  localparam logic [PHYS_W-1:0] RST_PHYS_SLOTS = 9'd256;
  localparam logic [SLOT_W-1:0] RST_START_SLOT = 8'd0;

  typedef logic [ACTION_W-1:0] action_t;
  localparam action_t ACT_READ  = 2'd0;
  localparam action_t ACT_WRITE = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_HIT       = 3'd0;
  localparam status_t ST_UNMAPPED  = 3'd1;
  localparam status_t ST_ALLOCATED = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_CLEARED   = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_PHYS_SLOTS = 2'd0;
  localparam cfg_idx_t REG_START_SLOT = 2'd1;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_LOOK,
    S_REPORT
  } ctrl_state_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic commit;
    logic clear;
  } alloc_ctl_t;

  typedef struct packed {
    logic              can_alloc;
    logic [SLOT_W-1:0] slot;
  } alloc_sts_t;

endpackage

// ===== sv/srmap_table.sv =====
`timescale 1ns / 1ps
module srmap_table
  import srmap_pkg::*;
#(
  parameter int LOGICAL_SECTORS = DEF_LOGICAL_SECTORS,
  localparam int IDX_W = (LOGICAL_SECTORS > 1) ? $clog2(LOGICAL_SECTORS) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data
);

  entry_t mem [LOGICAL_SECTORS];

  // read-first: a read at the written index returns the old entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

endmodule

// ===== sv/srmap_alloc.sv =====
`timescale 1ns / 1ps
module srmap_alloc
  import srmap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  alloc_ctl_t            alloc_ctl,
  output alloc_sts_t            alloc_sts
);

  logic [PHYS_W-1:0] phys_slots_r, phys_slots_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [PHYS_W-1:0] used_r, used_nxt;

  logic [PHYS_W-1:0] usable;
  logic [PHYS_W-1:0] slot_ext;
  logic [PHYS_W-1:0] slot_inc;
  logic [SLOT_W-1:0] ptr_adv;

  // saturate the slot count, wrap a stale pointer to slot zero
  always_comb begin
    usable    = (phys_slots_r > MAX_PHYS_SLOTS) ? MAX_PHYS_SLOTS : phys_slots_r;
    slot_ext  = ({1'b0, ptr_r} >= usable) ? '0 : {1'b0, ptr_r};
    slot_inc  = slot_ext + PHYS_W'(1);
    ptr_adv   = (slot_inc >= usable) ? '0 : slot_inc[SLOT_W-1:0];
    alloc_sts.can_alloc = (used_r < usable);
    alloc_sts.slot      = slot_ext[SLOT_W-1:0];
  end

  always_comb begin
    phys_slots_nxt = phys_slots_r;
    ptr_nxt        = ptr_r;
    used_nxt       = used_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHYS_SLOTS: phys_slots_nxt = cfg_data;
        REG_START_SLOT: ptr_nxt        = cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
    if (alloc_ctl.commit) begin
      ptr_nxt  = ptr_adv;
      used_nxt = used_r + PHYS_W'(1);
    end
    if (alloc_ctl.clear) begin
      used_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phys_slots_r <= RST_PHYS_SLOTS;
      ptr_r        <= RST_START_SLOT;
      used_r       <= '0;
    end else begin
      phys_slots_r <= phys_slots_nxt;
      ptr_r        <= ptr_nxt;
      used_r       <= used_nxt;
    end
  end

endmodule

// ===== sv/srmap_ctrl.sv =====
`timescale 1ns / 1ps
module srmap_ctrl
  import srmap_pkg::*;
#(
  parameter int LOGICAL_SECTORS = DEF_LOGICAL_SECTORS,
  localparam int IDX_W = (LOGICAL_SECTORS > 1) ? $clog2(LOGICAL_SECTORS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [SECTOR_W-1:0] in_logical_sector,
  input  logic [OFFSET_W-1:0] in_byte_offset,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_phys_address,
  output logic [STATUS_W-1:0] out_status,
  output logic                mem_rd_en,
  output logic [IDX_W-1:0]    mem_rd_idx,
  input  entry_t              mem_rd_data,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_wr_idx,
  output entry_t              mem_wr_data,
  output alloc_ctl_t          alloc_ctl,
  input  alloc_sts_t          alloc_sts
);

  ctrl_state_t state_r, state_nxt;

  action_t             act_r;
  logic [IDX_W-1:0]    idx_r;
  logic                in_range_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [IDX_W-1:0]    sweep_cnt_r, sweep_cnt_nxt;
  logic                report_r, report_nxt;
  logic                fwd_valid_r, fwd_valid_nxt;
  logic [IDX_W-1:0]    fwd_idx_r;
  logic [SLOT_W-1:0]   fwd_slot_r;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;

  logic [SECTOR_W+IDX_W-1:0] sector_ext;
  logic [IDX_W-1:0]          in_idx;
  logic                      in_range;
  logic                      accept;
  logic                      out_free;
  logic                      sweep_last;
  logic                      look_fire;
  entry_t                    entry;
  logic                      hit;
  logic                      do_alloc;
  status_t                   look_status;
  logic [ADDR_W-1:0]         look_addr;

  assign sector_ext = {{IDX_W{1'b0}}, in_logical_sector};
  assign in_idx     = sector_ext[IDX_W-1:0];
  assign in_range   = 32'(in_logical_sector) < 32'(LOGICAL_SECTORS);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_last = (sweep_cnt_r == IDX_W'(LOGICAL_SECTORS - 1));
  assign look_fire  = (state_r == S_LOOK) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP:  if (sweep_last) state_nxt = report_r ? S_REPORT : S_IDLE;
      S_IDLE: begin
        if (accept) state_nxt = (in_action == ACT_CLEAR) ? S_SWEEP : S_LOOK;
      end
      S_LOOK: begin
        if (accept) begin
          state_nxt = (in_action == ACT_CLEAR) ? S_SWEEP : S_LOOK;
        end else if (look_fire) begin
          state_nxt = S_IDLE;
        end
      end
      S_REPORT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_SWEEP;
    endcase
  end

  // outputs per state
  always_comb begin
    in_stall = 1'b1;
    unique case (state_r)
      S_SWEEP:  in_stall = 1'b1;
      S_IDLE:   in_stall = 1'b0;
      S_LOOK:   in_stall = !out_free;
      S_REPORT: in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  // forward the last allocation when the next lookup hits the same entry
  always_comb begin
    if (fwd_valid_r && (fwd_idx_r == idx_r)) begin
      entry.valid = 1'b1;
      entry.slot  = fwd_slot_r;
    end else begin
      entry = mem_rd_data;
    end
    hit      = in_range_r && entry.valid;
    do_alloc = (act_r == ACT_WRITE) && !hit && in_range_r && alloc_sts.can_alloc;
    if (hit) begin
      look_status = ST_HIT;
      look_addr   = {entry.slot, offset_r};
    end else if (do_alloc) begin
      look_status = ST_ALLOCATED;
      look_addr   = {alloc_sts.slot, offset_r};
    end else if (act_r == ACT_WRITE) begin
      look_status = ST_FULL;
      look_addr   = '0;
    end else begin
      look_status = ST_UNMAPPED;
      look_addr   = '0;
    end
  end

  always_comb begin
    mem_rd_en  = accept;
    mem_rd_idx = in_idx;
    if (state_r == S_SWEEP) begin
      mem_we            = 1'b1;
      mem_wr_idx        = sweep_cnt_r;
      mem_wr_data.valid = 1'b0;
      mem_wr_data.slot  = '0;
    end else begin
      mem_we            = look_fire && do_alloc;
      mem_wr_idx        = idx_r;
      mem_wr_data.valid = 1'b1;
      mem_wr_data.slot  = alloc_sts.slot;
    end
    alloc_ctl.commit = look_fire && do_alloc;
    alloc_ctl.clear  = (state_r == S_SWEEP) && sweep_last;
  end

  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    report_nxt    = report_r;
    fwd_valid_nxt = fwd_valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_status_nxt = out_status_r;
    if (state_r == S_SWEEP) begin
      sweep_cnt_nxt = sweep_last ? '0 : sweep_cnt_r + IDX_W'(1);
      fwd_valid_nxt = 1'b0;
    end
    if (accept && (in_action == ACT_CLEAR)) begin
      report_nxt = 1'b1;
    end
    if (look_fire) begin
      fwd_valid_nxt  = do_alloc;
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = look_addr;
      out_status_nxt = look_status;
    end
    if ((state_r == S_REPORT) && out_free) begin
      report_nxt     = 1'b0;
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = '0;
      out_status_nxt = ST_CLEARED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_cnt_r <= '0;
      report_r    <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      report_r    <= report_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= in_action;
      idx_r      <= in_idx;
      in_range_r <= in_range;
      offset_r   <= in_byte_offset;
    end
    if (look_fire) begin
      fwd_idx_r  <= idx_r;
      fwd_slot_r <= alloc_sts.slot;
    end
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_phys_address = out_addr_r;
  assign out_status       = out_status_r;

endmodule

// ===== sv/sector_remap_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in_       in_valid / in_stall    in_action, in_logical_sector, in_byte_offset
// out_      out_valid / out_stall  out_phys_address, out_status
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Lookups run back to back while the output is free: the table read issues on the
// input transfer, and the result loads into the output register as the next item
// enters. A clear sweeps every table entry, one per cycle, and the report state then
// loads the cleared result into the output register once the output is free.
// After reset the same sweep runs with in_stall high; cfg writes are never held.
// A stalled result holds in the output register; the lookup behind it waits.
module sector_remap_allocator
  import srmap_pkg::*;
#(
  parameter int LOGICAL_SECTORS = DEF_LOGICAL_SECTORS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [SECTOR_W-1:0]   in_logical_sector,
  input  logic [OFFSET_W-1:0]   in_byte_offset,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_W-1:0]     out_phys_address,
  output logic [STATUS_W-1:0]   out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (LOGICAL_SECTORS > 1) ? $clog2(LOGICAL_SECTORS) : 1;

  // table port wires
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_idx;
  entry_t           mem_rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wr_idx;
  entry_t           mem_wr_data;

  // allocator handshake: commit advances pointer and count, clear drops count
  alloc_ctl_t alloc_ctl;
  alloc_sts_t alloc_sts;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // one entry per logical sector: valid bit plus physical slot
  srmap_table #(
    .LOGICAL_SECTORS(LOGICAL_SECTORS)
  ) u_table (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_idx  (mem_rd_idx),
    .rd_data (mem_rd_data),
    .we      (mem_we),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data)
  );

  // slot count, wrapping pointer and used count
  srmap_alloc u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alloc_ctl (alloc_ctl),
    .alloc_sts (alloc_sts)
  );

  // sequencing, read-modify-write, forwarding and output register
  srmap_ctrl #(
    .LOGICAL_SECTORS(LOGICAL_SECTORS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_logical_sector (in_logical_sector),
    .in_byte_offset    (in_byte_offset),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_phys_address  (out_phys_address),
    .out_status        (out_status),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_idx        (mem_rd_idx),
    .mem_rd_data       (mem_rd_data),
    .mem_we            (mem_we),
    .mem_wr_idx        (mem_wr_idx),
    .mem_wr_data       (mem_wr_data),
    .alloc_ctl         (alloc_ctl),
    .alloc_sts         (alloc_sts)
  );

endmodule

// ===== sv/srmap_checker.sv =====
`timescale 1ns / 1ps
`include "sector_remap_allocator_macros.svh"
module srmap_checker
  import srmap_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [ACTION_W-1:0] in_action,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ADDR_W-1:0]   out_phys_address,
  input logic [STATUS_W-1:0] out_status
);

  // hold a stalled result
  `SRA_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_phys_address) && $stable(out_status), "stalled result changed")

  // only hits and allocations carry an address
  `SRA_ASSERT_CLK(a_addr_zero, out_valid && out_status != ST_HIT && out_status != ST_ALLOCATED |-> out_phys_address == '0, "address not zero on miss, full or clear")

  // a clear transfer starts the sweep, which blocks intake
  `SRA_ASSERT_CLK(a_clear_blocks, in_valid && !in_stall && in_action == ACT_CLEAR |=> in_stall, "intake open after clear transfer")

endmodule

bind sector_remap_allocator srmap_checker u_srmap_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_phys_address (out_phys_address),
  .out_status       (out_status)
);
